>>> rtl/core/mmh3_pkg.sv
// ----------------------------------------------------------------------------
// mmh3_pkg: shared types and constants for the MurmurHash3 x86_32 engine
// Mixing constants, controller states, datapath operation codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mmh3_pkg;

    localparam logic [31:0] C1       = 32'hcc9e2d51;
    localparam logic [31:0] C2       = 32'h1b873593;
    localparam logic [31:0] MIX_ADD  = 32'he6546b64;
    localparam logic [31:0] F1       = 32'h85ebca6b;
    localparam logic [31:0] F2       = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RST = 32'd40;

    typedef enum logic [3:0] {
        ST_IDLE,      // no key in progress
        ST_ACC,       // key in progress, waiting for next byte
        ST_MIX_C1,    // k *= C1
        ST_MIX_C2,    // k = rotl15(k) * C2
        ST_MIX_H,     // h = rotl13(h ^ k) * 5 + MIX_ADD
        ST_FIN_C1,    // k = tail * C1
        ST_FIN_C2,    // k = rotl15(k) * C2
        ST_FIN_CNT,   // h ^= k (if tail) ^ count
        ST_FIN_F1,    // h = (h ^ h >> 16) * F1
        ST_FIN_F2,    // h = (h ^ h >> 13) * F2
        ST_FIN_OUT    // result = h ^ h >> 16
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_BYTE,
        OP_MIX_C1,
        OP_SCR_C2,
        OP_MIX_H,
        OP_TAIL_C1,
        OP_FOLD,
        OP_AVAL1,
        OP_AVAL2,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic first;     // byte opens a new key
    } cmd_t;

    typedef struct packed {
        logic blk_full;  // current byte completes a 32-bit block
        logic out_free;  // output register can take a result this cycle
    } status_t;

endpackage

>>> rtl/core/mmh3_dp.sv
// ----------------------------------------------------------------------------
// mmh3_dp: MurmurHash3 datapath
// Seed register, block packing, byte count, one shared 32x32 multiplier and
// the output register.
// ----------------------------------------------------------------------------
module mmh3_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [7:0]        data_byte,
    input  mmh3_pkg::cmd_t    cmd,
    output mmh3_pkg::status_t status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       hash_value
);
    import mmh3_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] hash_reg,  hash_next;
    logic [31:0] k_reg,     k_next;
    logic [23:0] part_reg,  part_next;
    logic [31:0] cnt_reg,   cnt_next;
    logic [31:0] out_reg,   out_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] base_cnt;
    logic [23:0] base_part;
    logic [1:0]  pos;
    logic [23:0] lane;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] mix_x;
    logic        tail;

    assign base_cnt  = cmd.first ? 32'd0 : cnt_reg;
    assign base_part = cmd.first ? 24'd0 : part_reg;
    assign pos       = base_cnt[1:0];
    assign lane      = {16'd0, data_byte} << {pos, 3'b000};
    assign tail      = (cnt_reg[1:0] != 2'd0);
    assign mix_x     = {hash_reg[18:0] ^ k_reg[18:0], hash_reg[31:19] ^ k_reg[31:19]};

    assign status.blk_full = (pos == 2'd3);
    assign status.out_free = !out_valid_reg || out_ready;

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_MIX_C1:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
            OP_TAIL_C1:
            begin
                mul_a = {8'd0, part_reg};
                mul_b = C1;
            end
            OP_SCR_C2:
            begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = C2;
            end
            OP_AVAL1:
            begin
                mul_a = hash_reg ^ {16'd0, hash_reg[31:16]};
                mul_b = F1;
            end
            OP_AVAL2:
            begin
                mul_a = hash_reg ^ {13'd0, hash_reg[31:13]};
                mul_b = F2;
            end
            default:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        hash_next      = hash_reg;
        k_next         = k_reg;
        part_next      = part_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (cmd.op)
            OP_BYTE:
            begin
                if (cmd.first)
                begin
                    hash_next = seed_reg;
                end
                if (status.blk_full)
                begin
                    k_next    = {data_byte, base_part};
                    part_next = 24'd0;
                end
                else
                begin
                    part_next = base_part | lane;
                end
                cnt_next = base_cnt + 32'd1;
            end
            OP_MIX_C1, OP_TAIL_C1, OP_SCR_C2:
            begin
                k_next = mul_p;
            end
            OP_MIX_H:
            begin
                // x * 5 as x + 4x
                hash_next = mix_x + {mix_x[29:0], 2'b00} + MIX_ADD;
            end
            OP_FOLD:
            begin
                hash_next = hash_reg ^ (tail ? k_reg : 32'd0) ^ cnt_reg;
            end
            OP_AVAL1, OP_AVAL2:
            begin
                hash_next = mul_p;
            end
            OP_EMIT:
            begin
                out_next       = hash_reg ^ {16'd0, hash_reg[31:16]};
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        k_reg    <= k_next;
        part_reg <= part_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

endmodule

>>> rtl/core/mmh3_ctrl.sv
// ----------------------------------------------------------------------------
// mmh3_ctrl: MurmurHash3 sequencer
// Takes bytes, steps the datapath through block mixing and finalization.
// ----------------------------------------------------------------------------
module mmh3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              last_byte,
    input  mmh3_pkg::status_t status,
    output mmh3_pkg::cmd_t    cmd
);
    import mmh3_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg,  last_next;
    logic   xfer;

    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_ACC);
    assign xfer     = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE, ST_ACC:
            begin
                if (xfer)
                begin
                    last_next = last_byte;
                    priority if (status.blk_full)
                    begin
                        state_next = ST_MIX_C1;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_FIN_C1;
                    end
                    else
                    begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_MIX_C1:  state_next = ST_MIX_C2;
            ST_MIX_C2:  state_next = ST_MIX_H;
            ST_MIX_H:   state_next = last_reg ? ST_FIN_CNT : ST_ACC;
            ST_FIN_C1:  state_next = ST_FIN_C2;
            ST_FIN_C2:  state_next = ST_FIN_CNT;
            ST_FIN_CNT: state_next = ST_FIN_F1;
            ST_FIN_F1:  state_next = ST_FIN_F2;
            ST_FIN_F2:  state_next = ST_FIN_OUT;
            ST_FIN_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.first = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE, ST_ACC:
            begin
                if (xfer)
                begin
                    cmd.op = OP_BYTE;
                end
            end
            ST_MIX_C1:  cmd.op = OP_MIX_C1;
            ST_MIX_C2:  cmd.op = OP_SCR_C2;
            ST_MIX_H:   cmd.op = OP_MIX_H;
            ST_FIN_C1:  cmd.op = OP_TAIL_C1;
            ST_FIN_C2:  cmd.op = OP_SCR_C2;
            ST_FIN_CNT: cmd.op = OP_FOLD;
            ST_FIN_F1:  cmd.op = OP_AVAL1;
            ST_FIN_F2:  cmd.op = OP_AVAL2;
            ST_FIN_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> rtl/core/murmur3_32_hash_engine.sv
// ----------------------------------------------------------------------------
// murmur3_32_hash_engine: streaming MurmurHash3 x86_32
// Hashes a key fed one byte per transfer and returns the 32-bit hash.
// ----------------------------------------------------------------------------
// Feed the key one byte per input transfer (data_byte, in memory order) and
// raise last_byte on the final byte; one hash_value transfer follows per key.
// Empty keys cannot be expressed. Bytes are packed little-endian into 32-bit
// blocks. When a byte completes a block, the block is scrambled through the
// single shared 32x32 multiplier, one multiply per cycle, and mixed into the
// running hash, and no byte is taken meanwhile. After the last byte the
// engine runs the tail scramble, count fold, two avalanche multiplies and
// output when a 1..3 byte tail remains or, when the last byte closed a block,
// the block mix, then the count fold, two avalanche multiplies and output.
// The result sits in an output register; the next key can start as soon as
// that register has been loaded, and the engine only waits if a previous hash
// has not yet been taken. seed (reset value 40) is written through
// cfg_we/cfg_wdata, takes effect at the first byte of the next key, and
// should be changed only while idle.
// ----------------------------------------------------------------------------
module murmur3_32_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    // seed register
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // hash output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);
    import mmh3_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: byte intake, block mix and finalization steps
    mmh3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_byte (last_byte),
        .status    (status),
        .cmd       (cmd)
    );

    // hash state, shared multiplier and output register
    mmh3_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for murmur3_32_hash_engine
// Streams keys byte by byte and computes the expected MurmurHash3 x86_32 of
// each key alongside the engine. Every hash that comes out is compared with
// the oldest outstanding prediction. Runs directed keys, seed sweeps, then
// random traffic under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mmh3_pkg::*;

    // Cycles the engine may still be busy after its last hash is taken.
    localparam int DRAIN_CYCLES = 16;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = '0;
    logic        last_byte  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] hash_value;

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the seed and of the key in progress
    // ------------------------------------------------------------------------
    logic [31:0] seed_shadow = SEED_RST;
    logic [31:0] hash_acc    = '0;
    logic [23:0] tail_bytes  = '0;   // bytes of the block not yet complete
    logic [31:0] key_len     = '0;
    logic        key_busy    = 1'b0;

    logic [31:0] exp_hash_q[$];      // hashes predicted, not yet seen
    int          err_cnt     = 0;

    // Stall rates in percent for each side.
    int          in_idle_pct  = 0;
    int          out_idle_pct = 0;

    murmur3_32_hash_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Hash arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Block scramble: *C1, rotl 15, *C2.
    function automatic logic [31:0] scramble(input logic [31:0] k);
        logic [31:0] t;
        t = k * C1;
        t = rotl(t, 15);
        t = t * C2;
        return t;
    endfunction

    // Final avalanche mix.
    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * F1;
        t = t ^ (t >> 13);
        t = t * F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Fold one accepted byte into the predicted key state; on the final byte
    // finish the hash and queue it.
    task automatic hash_key_byte(input logic [7:0] b, input logic fin);
        logic [31:0] h;
        logic [1:0]  slot;
        if (!key_busy)
        begin
            hash_acc   = seed_shadow;   // seed latched at the key's first byte
            tail_bytes = '0;
            key_len    = '0;
            key_busy   = 1'b1;
        end
        slot = key_len[1:0];
        if (slot == 2'd3)
        begin
            // Fourth byte closes a little-endian block: mix it in.
            h          = hash_acc ^ scramble({b, tail_bytes});
            hash_acc   = rotl(h, 13) * 32'd5 + MIX_ADD;
            tail_bytes = '0;
        end
        else
        begin
            tail_bytes[8*slot +: 8] = b;
        end
        key_len = key_len + 32'd1;
        if (fin)
        begin
            h = hash_acc;
            if (key_len[1:0] != 2'd0)
                h = h ^ scramble({8'h00, tail_bytes});
            h = h ^ key_len;
            exp_hash_q.push_back(avalanche(h));
            key_busy = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random backpressure on the hash output
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99, 0) >= out_idle_pct);

    // ------------------------------------------------------------------------
    // Result checker: each hash transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_hash_q.size() == 0)
            begin
                $display("%0t: unexpected hash transfer, got %08h", $time, hash_value);
                err_cnt++;
            end
            else
            begin
                if (hash_value !== exp_hash_q[0])
                begin
                    $display("%0t: hash_value mismatch, expected %08h actual %08h",
                             $time, exp_hash_q[0], hash_value);
                    err_cnt++;
                end
                void'(exp_hash_q.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One byte transfer, with random idle cycles ahead of it. Valid stays up
    // straight into the next byte when no idle cycle is drawn.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99, 0) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_key_byte(b, fin);
    endtask

    // Whole key, last flag on its final byte.
    task automatic send_key(input logic [7:0] kb[$]);
        foreach (kb[i])
            send_byte(kb[i], i == kb.size() - 1);
    endtask

    // Random key content; a share of bytes pinned to all-zero / all-one.
    task automatic send_random_key(input int len);
        logic [7:0] kb[$];
        int         pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(9, 0);
            if (pick == 0)
                kb.push_back(8'h00);
            else if (pick == 1)
                kb.push_back(8'hff);
            else
                kb.push_back(8'($urandom));
        end
        send_key(kb);
    endtask

    // Hold the input idle until every predicted hash has come back, then let
    // the engine settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_hash_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Seed write; only called with the engine drained.
    task automatic write_seed(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_shadow = v;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset seed, short keys covering every tail length and extreme bytes:
    // one-byte keys, 2/3-byte tails, exact blocks, block plus tail.
    task automatic test_directed_keys;
        send_key('{8'h00});
        send_key('{8'hff});
        send_key('{8'h00, 8'h00});
        send_key('{8'hff, 8'hff, 8'hff});
        send_key('{8'hff, 8'hff, 8'hff, 8'hff});
        send_key('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
        send_key('{8'h80, 8'h7f, 8'h55, 8'haa, 8'h01, 8'hfe, 8'h00, 8'hff});
        drain();
    endtask

    // Seed at both extremes and a random value; a key of each tail length.
    task automatic test_seed_sweep;
        logic [31:0] seeds[3];
        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hffff_ffff;
        seeds[2] = $urandom;
        foreach (seeds[s])
        begin
            write_seed(seeds[s]);
            for (int len = 1; len <= 4; len++)
                send_random_key(len);
            drain();
        end
    endtask

    // Random keys, mostly short, now and then long. With mid_pause the
    // sender stops halfway until every hash is back.
    task automatic test_random_traffic(input int n_bytes, input bit mid_pause);
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(9, 0) == 0)
                len = $urandom_range(64, 13);
            else
                len = $urandom_range(12, 1);
            send_random_key(len);
            sent += len;
            if (mid_pause && !paused && sent >= n_bytes / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender rarely idle, receiver mostly stalled.
        in_idle_pct  = 9;
        out_idle_pct = 61;
        test_directed_keys();
        test_seed_sweep();
        write_seed($urandom);
        test_random_traffic(200, 1'b1);

        // Sender mostly idle, receiver rarely stalled.
        in_idle_pct  = 61;
        out_idle_pct = 9;
        write_seed($urandom);
        test_random_traffic(200, 1'b0);

        // Full rate both sides, back to the reset seed value.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_seed(SEED_RST);
        test_random_traffic(200, 1'b0);

        if (err_cnt == 0 && exp_hash_q.size() == 0)
            $display("murmur3_32_hash_engine verification clean");
        else
            $display("murmur3_32_hash_engine verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("murmur3_32_hash_engine verification failed");
        $finish;
    end

endmodule

>>> murmur3_32_hash_engine.f
rtl/core/mmh3_pkg.sv
rtl/core/mmh3_dp.sv
rtl/core/mmh3_ctrl.sv
rtl/core/murmur3_32_hash_engine.sv
bench/tb.sv
